// ===== hdl/stq_pkg.sv =====
// Package for the sorted timer event queue: sizes, operation and result codes,
// the sequencer state type and the bus widths. It depends on nothing else.
package stq_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int NUM_IDS    = (NUM_TIMERS < 8) ? NUM_TIMERS : 8;
    localparam int ID_W       = 3;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W     = 32;

    localparam logic [TIME_W-1:0] EXPIRY_WINDOW = 32'h7fff_ffff;
    localparam logic [TIME_W-1:0] EMPTY_DELAY   = 32'd1000;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_UNQ,
        ST_ADD_C,
        ST_ADD_EXP,
        ST_ADD_SCAN,
        ST_ADD_INS,
        ST_REM,
        ST_RESP,
        ST_CHK_C,
        ST_CHK
    } state_t;

endpackage

// ===== hdl/sorted_timer_event_queue_unit.sv =====
// An add removes any old entry, forms two offsets, checks expiry, scans past
// each earlier queued timer and inserts; remove and unknown requests respond
// directly; a check reports each fired timer, then a check result. Throughput
// is one transaction at a time, paced by the shared subtractor that forms
// anchor-relative offsets. Reset (rst_n low, asynchronous) empties the queue
// and zeroes the anchor. Depends on stq_pkg.
module sorted_timer_event_queue_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // timer_id [2:0], new_timeout [34:3], current_time [66:35], zero fill
    input  logic [stq_pkg::IN_TDATA_W-1:0]   s_tdata,
    // op [1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fired_id [2:0], fired_time [34:3], deadline [66:35],
    // deadline_valid [67], check_return [99:68], zero fill
    output logic [stq_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // event_kind [1:0]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);
    import stq_pkg::*;

    state_t                  state_reg, state_next;
    logic [ID_W-1:0]         order_reg [NUM_TIMERS];
    logic [ID_W-1:0]         order_next [NUM_TIMERS];
    logic [TIME_W-1:0]       dl_reg [NUM_TIMERS];
    logic [TIME_W-1:0]       dl_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   flag_reg, flag_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TIME_W-1:0]       anchor_reg, anchor_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [TIME_W-1:0]       tmo_reg, tmo_next;
    logic [TIME_W-1:0]       cur_reg, cur_next;
    logic [TIME_W-1:0]       a_reg, a_next;
    logic [TIME_W-1:0]       c_reg, c_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              kind_reg, kind_next;
    logic [ID_W-1:0]         fid_reg, fid_next;
    logic [TIME_W-1:0]       ftime_reg, ftime_next;
    logic [TIME_W-1:0]       dline_reg, dline_next;
    logic                    dvalid_reg, dvalid_next;
    logic [TIME_W-1:0]       cret_reg, cret_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    id_known;
    logic [TIME_W-1:0]       sub_x, sub_y, sub_diff;
    logic [TIME_W-1:0]       head_dl;
    logic [TIME_W-1:0]       scan_dl;

    logic [ID_W-1:0]         uq_id;
    logic [ID_W-1:0]         uq_order [NUM_TIMERS];
    logic [CNT_W-1:0]        uq_count;
    logic [NUM_TIMERS-1:0]   uq_flags;
    logic                    uq_found;
    logic [IDX_W-1:0]        uq_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, cret_reg, dvalid_reg, dline_reg, ftime_reg, fid_reg};

    assign out_free = !m_valid_reg || m_tready;
    assign id_known = (32'(id_reg) < NUM_IDS);
    assign head_dl  = dl_reg[order_reg[0]];
    assign scan_dl  = dl_reg[order_reg[pos_reg[IDX_W-1:0]]];
    assign sub_diff = sub_x - sub_y;

    // Removal of one timer from the ordered list.
    always_comb
    begin
        uq_found = 1'b0;
        uq_idx   = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (!uq_found && (CNT_W'(i) < count_reg) && (order_reg[i] == uq_id))
            begin
                uq_found = 1'b1;
                uq_idx   = IDX_W'(i);
            end
        end
        uq_flags        = flag_reg;
        uq_flags[uq_id] = 1'b0;
        uq_count        = count_reg;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            uq_order[j] = order_reg[j];
        end
        if (flag_reg[uq_id] && uq_found)
        begin
            uq_count = count_reg - 1'b1;
            for (int j = 0; j < NUM_TIMERS - 1; j++)
            begin
                if (IDX_W'(j) >= uq_idx)
                begin
                    uq_order[j] = order_reg[j + 1];
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        flag_next    = flag_reg;
        count_next   = count_reg;
        anchor_next  = anchor_reg;
        id_next      = id_reg;
        tmo_next     = tmo_reg;
        cur_next     = cur_reg;
        a_next       = a_reg;
        c_next       = c_reg;
        pos_next     = pos_reg;
        kind_next    = kind_reg;
        fid_next     = fid_reg;
        ftime_next   = ftime_reg;
        dline_next   = dline_reg;
        dvalid_next  = dvalid_reg;
        cret_next    = cret_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_next[j] = order_reg[j];
            dl_next[j]    = dl_reg[j];
        end
        uq_id = id_reg;
        sub_x = cur_reg;
        sub_y = anchor_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next  = s_tdata[2:0];
                    tmo_next = s_tdata[34:3];
                    cur_next = s_tdata[66:35];
                    unique case (op_t'(s_tuser))
                        OP_ADD:    state_next = ST_ADD_UNQ;
                        OP_REMOVE: state_next = ST_REM;
                        OP_CHECK:  state_next = ST_CHK_C;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_ADD_UNQ:
            begin
                sub_x = tmo_reg;
                a_next = sub_diff;
                if (id_known)
                begin
                    for (int j = 0; j < NUM_TIMERS; j++)
                    begin
                        order_next[j] = uq_order[j];
                    end
                    flag_next  = uq_flags;
                    count_next = uq_count;
                    state_next = ST_ADD_C;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_ADD_C:
            begin
                c_next     = sub_diff;
                state_next = ST_ADD_EXP;
            end
            ST_ADD_EXP:
            begin
                pos_next = '0;
                if ((a_reg - EXPIRY_WINDOW) < (c_reg - EXPIRY_WINDOW))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_ADD_SCAN;
                end
            end
            ST_ADD_SCAN:
            begin
                sub_x = scan_dl;
                if ((pos_reg < count_reg) && (a_reg > sub_diff))
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_ADD_INS;
                end
            end
            ST_ADD_INS:
            begin
                if (out_free)
                begin
                    for (int j = 0; j < NUM_TIMERS; j++)
                    begin
                        if (CNT_W'(j) == pos_reg)
                        begin
                            order_next[j] = id_reg;
                        end
                        else if (CNT_W'(j) > pos_reg)
                        begin
                            order_next[j] = order_reg[IDX_W'(j - 1)];
                        end
                    end
                    dl_next[id_reg]   = tmo_reg;
                    flag_next[id_reg] = 1'b1;
                    count_next        = count_reg + 1'b1;
                    m_valid_next      = 1'b1;
                    kind_next         = KIND_DONE;
                    fid_next          = '0;
                    ftime_next        = '0;
                    dline_next        = (pos_reg == '0) ? tmo_reg : head_dl;
                    dvalid_next       = 1'b1;
                    cret_next         = '0;
                    last_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_REM:
            begin
                if (out_free)
                begin
                    if (id_known)
                    begin
                        for (int j = 0; j < NUM_TIMERS; j++)
                        begin
                            order_next[j] = uq_order[j];
                        end
                        flag_next  = uq_flags;
                        count_next = uq_count;
                    end
                    m_valid_next = 1'b1;
                    kind_next    = KIND_DONE;
                    fid_next     = '0;
                    ftime_next   = '0;
                    dline_next   = '0;
                    dvalid_next  = 1'b0;
                    cret_next    = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_DONE;
                    fid_next     = '0;
                    ftime_next   = '0;
                    dline_next   = '0;
                    dvalid_next  = 1'b0;
                    cret_next    = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHK_C:
            begin
                c_next     = sub_diff;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                uq_id = order_reg[0];
                sub_x = head_dl;
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    fid_next     = '0;
                    ftime_next   = '0;
                    dline_next   = '0;
                    dvalid_next  = 1'b0;
                    cret_next    = '0;
                    if (count_reg == '0)
                    begin
                        kind_next  = KIND_CHECK;
                        cret_next  = cur_reg + EMPTY_DELAY;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (sub_diff > c_reg)
                    begin
                        anchor_next = cur_reg;
                        kind_next   = KIND_CHECK;
                        dline_next  = head_dl;
                        dvalid_next = 1'b1;
                        cret_next   = head_dl - cur_reg;
                        last_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        for (int j = 0; j < NUM_TIMERS; j++)
                        begin
                            order_next[j] = uq_order[j];
                        end
                        flag_next  = uq_flags;
                        count_next = uq_count;
                        kind_next  = KIND_FIRED;
                        fid_next   = order_reg[0];
                        ftime_next = head_dl;
                        last_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            flag_reg    <= '0;
            count_reg   <= '0;
            anchor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            count_reg   <= count_next;
            anchor_reg  <= anchor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_reg[j] <= order_next[j];
            dl_reg[j]    <= dl_next[j];
        end
        id_reg     <= id_next;
        tmo_reg    <= tmo_next;
        cur_reg    <= cur_next;
        a_reg      <= a_next;
        c_reg      <= c_next;
        pos_reg    <= pos_next;
        kind_reg   <= kind_next;
        fid_reg    <= fid_next;
        ftime_reg  <= ftime_next;
        dline_reg  <= dline_next;
        dvalid_reg <= dvalid_next;
        cret_reg   <= cret_next;
        last_reg   <= last_next;
    end

endmodule

// ===== hdl/stq_checker.sv =====
// Port-level checks for the sorted timer event queue, bound to its top level.
// Depends on stq_pkg and sorted_timer_event_queue_unit.
module stq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stq_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             m_tlast
);
    import stq_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One transaction is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Only fired results leave the run open.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_FIRED)))
        else $error("last flag disagrees with event kind");

    // A fired result never carries a new deadline.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[67] |-> m_tuser != KIND_FIRED)
        else $error("deadline reported on fired result");

    // The unused event kind never appears on a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != KIND_UNUSED)
        else $error("unused event kind on result");

endmodule

bind sorted_timer_event_queue_unit stq_checker u_stq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
